FILE: src/awo_pkg.sv
package awo_pkg;

  localparam int PHASE_BITS_DEF      = 24;
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int SAMPLE_BITS_DEF     = 16;

  localparam int STEP_BITS     = 23;
  localparam int STEP_REF_BITS = 24;
  localparam int WAVE_BITS     = 2;
  localparam int VOLUME_BITS   = 16;
  localparam int WEIGHT_BITS   = 17;
  localparam int MULT_BITS     = 6;
  localparam int NUM_HARM      = 6;
  localparam int HARM_LAST     = NUM_HARM + 2;
  localparam int CNT_BITS      = 4;
  localparam int HARM_BITS     = 3;

  localparam logic [VOLUME_BITS-1:0] VOLUME_RESET = 16'd26214;

  localparam logic REG_VOLUME = 1'b0;

  localparam logic [WAVE_BITS-1:0] WAVE_SINE    = 2'd0;
  localparam logic [WAVE_BITS-1:0] WAVE_SAW     = 2'd1;
  localparam logic [WAVE_BITS-1:0] WAVE_SQUARE  = 2'd2;
  localparam logic [WAVE_BITS-1:0] WAVE_SQUARES = 2'd3;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_HARM   = 6'b000010,
    ST_VOL_HI = 6'b000100,
    ST_VOL_LO = 6'b001000,
    ST_SUM_P  = 6'b010000,
    ST_ROUND  = 6'b100000
  } state_t;

  localparam longint unsigned CA1 = 64'd1686629713;
  localparam longint unsigned CA3 = 64'd693598668;
  localparam longint unsigned CA5 = 64'd85569306;
  localparam longint unsigned CA7 = 64'd5026995;
  localparam longint unsigned CA9 = 64'd172269;

  function automatic logic [MULT_BITS-1:0] harm_mult(logic [WAVE_BITS-1:0] wave,
                                                     logic [HARM_BITS-1:0] k);
    logic [MULT_BITS-1:0] m;
    m = '0;
    case (wave)
      WAVE_SINE:    m = (k == 3'd0) ? 6'd1 : 6'd0;
      WAVE_SAW:     m = MULT_BITS'(k) + 6'd1;
      WAVE_SQUARE:  m = MULT_BITS'({k, 1'b1});
      WAVE_SQUARES: m = (MULT_BITS'(k) + 6'd1) * (MULT_BITS'(k) + 6'd1);
      default:      m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [WEIGHT_BITS-1:0] harm_weight(logic [WAVE_BITS-1:0] wave,
                                                         logic [HARM_BITS-1:0] k);
    logic [WEIGHT_BITS-1:0] w;
    w = '0;
    case (wave)
      WAVE_SINE: w = (k == 3'd0) ? 17'd65536 : 17'd0;
      WAVE_SAW: begin
        case (k)
          3'd0:    w = 17'd45875;
          3'd1:    w = 17'd22938;
          3'd2:    w = 17'd15292;
          3'd3:    w = 17'd11469;
          3'd4:    w = 17'd9175;
          3'd5:    w = 17'd7646;
          default: w = '0;
        endcase
      end
      WAVE_SQUARE: begin
        case (k)
          3'd0:    w = 17'd65536;
          3'd1:    w = 17'd21845;
          3'd2:    w = 17'd13107;
          3'd3:    w = 17'd9362;
          3'd4:    w = 17'd7282;
          3'd5:    w = 17'd5958;
          default: w = '0;
        endcase
      end
      WAVE_SQUARES: begin
        case (k)
          3'd0:    w = 17'd65536;
          3'd1:    w = 17'd16384;
          3'd2:    w = 17'd7282;
          3'd3:    w = 17'd4096;
          3'd4:    w = 17'd2621;
          3'd5:    w = 17'd1820;
          default: w = '0;
        endcase
      end
      default: w = '0;
    endcase
    return w;
  endfunction

  // quarter-wave odd polynomial, evaluated at elaboration for the table
  function automatic int sine_entry(int tb, int sb, int idx);
    longint unsigned n4, quad, r, x, x2, t, y, mag, amp;
    n4   = 64'd1 << (tb - 2);
    quad = (longint'(idx) >> (tb - 2)) & 64'd3;
    r    = longint'(idx) & (n4 - 64'd1);
    amp  = (64'd1 << (sb - 1)) - 64'd1;
    if (quad[0]) begin
      r = n4 - r;
    end
    x   = r << (30 - (tb - 2));
    x2  = (x * x) >> 30;
    t   = CA7 - ((x2 * CA9) >> 30);
    t   = CA5 - ((x2 * t) >> 30);
    t   = CA3 - ((x2 * t) >> 30);
    t   = CA1 - ((x2 * t) >> 30);
    y   = (x * t) >> 30;
    mag = (y * amp + (64'd1 << 29)) >> 30;
    if (mag > amp) begin
      mag = amp;
    end
    return quad[1] ? -int'(mag) : int'(mag);
  endfunction

endpackage

FILE: src/additive_waveform_oscillator_unit.sv
// one beat at a time: in_stall is high from the accepted beat until the finished
// sample enters the output register; six harmonic passes through the sine
// table and the one shared multiplier, then two volume passes and rounding
// reset (rst, synchronous): phase cleared, volume back to 0.4, no output pending
// a finished sample waits in the output register while the next beat is taken
module additive_waveform_oscillator_unit #(
  parameter int PHASE_BITS      = awo_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = awo_pkg::SINE_TABLE_BITS_DEF,
  parameter int SAMPLE_BITS     = awo_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [awo_pkg::STEP_BITS-1:0]        phase_step,
  input  logic [awo_pkg::WAVE_BITS-1:0]        waveform,
  input  logic                                 note_start,
  input  logic                                 silent,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_BITS-1:0]        sample
);
  import awo_pkg::*;

  localparam int TAB_DEPTH = 2 ** SINE_TABLE_BITS;
  localparam int SUM_W     = SAMPLE_BITS + 18;
  localparam int PW        = SUM_W + 16;
  localparam int RND_W     = PW - 32;
  localparam int MA        = (SAMPLE_BITS + 3 > 17) ? SAMPLE_BITS + 3 : 17;
  localparam int MQ        = MA + 18;
  localparam int SH_L      = (PHASE_BITS >= STEP_REF_BITS) ? PHASE_BITS - STEP_REF_BITS : 0;
  localparam int SH_R      = (PHASE_BITS >= STEP_REF_BITS) ? 0 : STEP_REF_BITS - PHASE_BITS;
  localparam int STEP_W    = STEP_BITS + 16;

  localparam logic [RND_W-1:0] AMP     = RND_W'((2 ** (SAMPLE_BITS - 1)) - 1);
  localparam logic [RND_W-1:0] AMP_NEG = RND_W'(2 ** (SAMPLE_BITS - 1));
  localparam logic [PW-1:0]    HALF    = PW'(64'd1 << 31);

  logic signed [SAMPLE_BITS-1:0] sine_rom [TAB_DEPTH];

  for (genvar i = 0; i < TAB_DEPTH; i++) begin : g_rom
    assign sine_rom[i] = SAMPLE_BITS'(sine_entry(SINE_TABLE_BITS, SAMPLE_BITS, i));
  end

  state_t                        state;
  logic [VOLUME_BITS-1:0]        volume;
  logic [PHASE_BITS-1:0]         phase;
  logic [PHASE_BITS-1:0]         ph;
  logic [WAVE_BITS-1:0]          wave;
  logic                          mute;
  logic [CNT_BITS-1:0]           cnt;
  logic [SINE_TABLE_BITS-1:0]    angle_idx;
  logic [WEIGHT_BITS-1:0]        w1;
  logic [WEIGHT_BITS-1:0]        w2;
  logic signed [SAMPLE_BITS-1:0] rom_q;
  logic                          v1;
  logic                          v2;
  logic                          v3;
  logic signed [MQ-1:0]          mul_q;
  logic signed [SUM_W-1:0]       sum;
  logic signed [PW-1:0]          prod;

  logic                          accept;
  logic                          cfg_write;
  logic                          out_free;
  logic [PHASE_BITS-1:0]         phase_cur;
  logic [STEP_W-1:0]             step_wide;
  logic [PHASE_BITS-1:0]         angle;
  logic [HARM_BITS-1:0]          k;
  logic signed [MA-1:0]          mul_a;
  logic signed [17:0]            mul_b;
  logic [PW-1:0]                 mag;
  logic [PW-1:0]                 mag_rnd;
  logic [RND_W-1:0]              rnd;
  logic [RND_W-1:0]              sat;
  logic [SAMPLE_BITS-1:0]        sample_next;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_VOLUME);
  assign prdata    = (paddr[2] == REG_VOLUME) ? 32'(volume) : 32'd0;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign phase_cur = note_start ? '0 : phase;
  assign step_wide = (STEP_W'(phase_step) << SH_L) >> SH_R;

  assign k     = cnt[HARM_BITS-1:0];
  assign angle = ph * PHASE_BITS'(harm_mult(wave, k));

  always_comb begin
    mul_a = MA'(rom_q);
    mul_b = $signed({1'b0, w2});
    case (state)
      ST_VOL_HI: begin
        mul_a = MA'($signed(sum[SUM_W-1:16]));
        mul_b = $signed({2'b00, volume});
      end
      ST_VOL_LO: begin
        mul_a = MA'($signed({1'b0, sum[15:0]}));
        mul_b = $signed({2'b00, volume});
      end
      default: begin
        mul_a = MA'(rom_q);
        mul_b = $signed({1'b0, w2});
      end
    endcase
  end

  // round half away from zero, then clamp; a muted note gives zero
  always_comb begin
    mag     = prod[PW-1] ? PW'(-prod) : PW'(prod);
    mag_rnd = mag + HALF;
    rnd     = mag_rnd[PW-1:32];
    if (prod[PW-1]) begin
      sat = (rnd > AMP_NEG) ? AMP_NEG : rnd;
      sample_next = SAMPLE_BITS'(-sat);
    end else begin
      sat = (rnd > AMP) ? AMP : rnd;
      sample_next = SAMPLE_BITS'(sat);
    end
    if (mute) begin
      sample_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      volume <= VOLUME_RESET;
    end else if (cfg_write) begin
      volume <= pwdata[VOLUME_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= '0;
      cnt       <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_ROUND && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            phase <= phase_cur + step_wide[PHASE_BITS-1:0];
            cnt   <= '0;
            state <= ST_HARM;
          end
        end
        ST_HARM: begin
          v1 <= (cnt < CNT_BITS'(NUM_HARM));
          v2 <= v1;
          v3 <= v2;
          if (cnt == CNT_BITS'(HARM_LAST)) begin
            state <= ST_VOL_HI;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_VOL_HI: begin
          v1    <= 1'b0;
          v2    <= 1'b0;
          v3    <= 1'b0;
          state <= ST_VOL_LO;
        end
        ST_VOL_LO: begin
          state <= ST_SUM_P;
        end
        ST_SUM_P: begin
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ph   <= phase_cur;
      wave <= waveform;
      mute <= silent;
      sum  <= '0;
    end
    angle_idx <= angle[PHASE_BITS-1 -: SINE_TABLE_BITS];
    w1        <= harm_weight(wave, k);
    rom_q     <= sine_rom[angle_idx];
    w2        <= w1;
    mul_q     <= mul_a * mul_b;
    if (state == ST_HARM && v3) begin
      sum <= sum + SUM_W'(mul_q);
    end
    if (state == ST_VOL_LO) begin
      prod <= PW'(mul_q) << 16;
    end
    if (state == ST_SUM_P) begin
      prod <= prod + PW'(mul_q);
    end
    if (state == ST_ROUND && out_free) begin
      sample <= sample_next;
    end
  end

endmodule
